/* src/rbb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, constants and helpers of the RGB 3x3 box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int unsigned MAX_WIDTH_DEF   = 2048;
  localparam int unsigned MAX_HEIGHT_DEF  = 2048;
  localparam int unsigned FRAME_WIDTH_RST = 800;
  localparam int unsigned FRAME_HEIGHT_RST = 600;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned RECIP_SH   = 16;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_LAST,
    ST_MUL,
    ST_DONE
  } rbb_state_e;

  // ceil(2^16 / n): exact floor division for sums up to 9 * 255
  function automatic logic [RECIP_W-1:0] mean_recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/rbb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_if
// Handshake channels of the RGB 3x3 box blur: pixel in, mean out, config.
// ----------------------------------------------------------------------------
interface rbb_pix_if import rbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, cmd, red_in, green_in, blue_in, output ready);
endinterface

interface rbb_res_if import rbb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic            frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

interface rbb_cfg_if import rbb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/rbb_line_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_line_mem
// Four rotating pixel rows, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rbb_line_mem import rbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [1:0]       wrow_i,
  input  logic [CW-1:0]    wcol_i,
  input  logic [PIX_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [1:0]       rrow_i,
  input  logic [CW-1:0]    rcol_i,
  output logic [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] line_mem [4][MAX_WIDTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      line_mem[wrow_i][wcol_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= line_mem[rrow_i][rcol_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rgb_box_blur_3x3_top.sv */
`timescale 1ns / 1ps
// Flow: a pixel or drain word that yields no mean leaves the block in ST_IDLE,
//   ready for the next word; one that yields a mean passes ST_GATHER, ST_LAST,
//   ST_MUL and ST_DONE to the output register, which can stall it, and no word
//   is taken meanwhile; the nine neighbor slots share the single line memory read port.
// Reset: positions cleared, width 800 and height 600; line memory is not
//   cleared, no clearing pass.
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3_top
// Streaming 3x3 mean filter on RGB pixels with border-aware divisor.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3_top import rbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbb_cfg_if.sink   cfg_i,
  rbb_pix_if.sink   pix_i,
  rbb_res_if.source res_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WVW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HVW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned RST_W =
    (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int unsigned RST_H =
    (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  rbb_state_e state_q, state_d;

  logic [WVW-1:0] w_q;
  logic [HVW-1:0] h_q;
  logic [CW-1:0]  in_col_q;
  logic [HVW-1:0] in_row_q;
  logic [CW-1:0]  out_col_q;
  logic [RW-1:0]  out_row_q;
  logic [PW-1:0]  pend_q;

  logic [CW-1:0]  gco_q;
  logic [RW-1:0]  gro_q;
  logic           gfin_q;
  logic [1:0]     sr_q, sc_q;
  logic [CNT_W-1:0] cnt_q;
  logic           rd_vld_q;
  logic [SUM_W-1:0] acc_q [3];
  logic [CH_W-1:0]  mean_q [3];
  logic [PROD_W-1:0] prod [3];

  logic            out_vld_q, out_fin_q;
  logic [CH_W-1:0] out_r_q, out_g_q, out_b_q;

  logic pix_ready, cfg_ready, out_load;
  logic pix_acc, cfg_acc;
  logic frame_full, is_drain, pix_write, emit_pix, emit_drain, emit;
  logic out_last, in_col_last, out_col_last;
  logic slot_vld, last_slot;
  logic [1:0]      rrow;
  logic [CW-1:0]   rcol;
  logic [PIX_W-1:0] rdata;
  logic [CFG_DATA_W-1:0] cfg_val;

  assign cfg_acc = cfg_i.valid && cfg_ready;
  assign pix_acc = pix_i.valid && pix_ready;
  assign cfg_i.ready = cfg_ready;
  assign pix_i.ready = pix_ready;

  assign frame_full   = (in_row_q == h_q);
  assign is_drain     = (pix_i.cmd == CMD_DRAIN);
  assign pix_write    = pix_acc && !is_drain && !frame_full;
  assign emit_pix     = pix_write && (pend_q >= PW'(w_q) + PW'(1));
  assign emit_drain   = pix_acc && is_drain && frame_full;
  assign emit         = emit_pix || emit_drain;
  assign in_col_last  = (WVW'(in_col_q) + WVW'(1) == w_q);
  assign out_col_last = (WVW'(out_col_q) + WVW'(1) == w_q);
  assign out_last     = out_col_last && (HVW'(out_row_q) + HVW'(1) == h_q);

  // neighbor slot address and in-image test
  assign rrow = 2'(gro_q) + sr_q + 2'd3;
  assign rcol = CW'(gco_q + CW'(sc_q) - CW'(1));
  assign slot_vld = !(sr_q == 2'd0 && gro_q == '0)
                 && !(sr_q == 2'd2 && HVW'(gro_q) + HVW'(1) == h_q)
                 && !(sc_q == 2'd0 && gco_q == '0)
                 && !(sc_q == 2'd2 && WVW'(gco_q) + WVW'(1) == w_q);
  assign last_slot = (sr_q == 2'd2) && (sc_q == 2'd2);

  rbb_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (pix_write),
    .wrow_i  (2'(in_row_q)),
    .wcol_i  (in_col_q),
    .wdata_i ({pix_i.red_in, pix_i.green_in, pix_i.blue_in}),
    .re_i    ((state_q == ST_GATHER) && slot_vld),
    .rrow_i  (rrow),
    .rcol_i  (rcol),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(acc_q[i]) * PROD_W'(mean_recip(cnt_q));
    end
  end

  always_comb begin
    state_d   = state_q;
    pix_ready = 1'b0;
    cfg_ready = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        pix_ready = !cfg_i.valid;
        if (emit) begin
          state_d = ST_GATHER;
        end
      end
      ST_GATHER: begin
        if (last_slot) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cfg_val = cfg_i.data;

  // frame geometry and raster positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WVW'(RST_W);
      h_q       <= HVW'(RST_H);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
      gco_q     <= '0;
      gro_q     <= '0;
      gfin_q    <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_i.index)
          CFG_FRAME_WIDTH: begin
            if (cfg_val == '0) begin
              w_q <= WVW'(1);
            end else if (32'(cfg_val) > 32'(MAX_WIDTH)) begin
              w_q <= WVW'(MAX_WIDTH);
            end else begin
              w_q <= WVW'(cfg_val);
            end
          end
          CFG_FRAME_HEIGHT: begin
            if (cfg_val == '0) begin
              h_q <= HVW'(1);
            end else if (32'(cfg_val) > 32'(MAX_HEIGHT)) begin
              h_q <= HVW'(MAX_HEIGHT);
            end else begin
              h_q <= HVW'(cfg_val);
            end
          end
          default: ;
        endcase
        if (cfg_i.index == CFG_FRAME_WIDTH || cfg_i.index == CFG_FRAME_HEIGHT) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          pend_q    <= '0;
        end
      end
      if (pix_write) begin
        if (in_col_last) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + HVW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
        if (!emit_pix) begin
          pend_q <= pend_q + PW'(1);
        end
      end
      if (emit_drain && !out_last) begin
        pend_q <= pend_q - PW'(1);
      end
      if (emit) begin
        gco_q  <= out_col_q;
        gro_q  <= out_row_q;
        gfin_q <= out_last;
        if (out_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
          pend_q    <= '0;
        end else if (out_col_last) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // neighbor sweep and accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q     <= '0;
      sc_q     <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_GATHER) && slot_vld;
      if (state_q == ST_IDLE) begin
        sr_q  <= '0;
        sc_q  <= '0;
        cnt_q <= '0;
      end else if (state_q == ST_GATHER) begin
        if (sc_q == 2'd2) begin
          sc_q <= '0;
          sr_q <= sr_q + 2'd1;
        end else begin
          sc_q <= sc_q + 2'd1;
        end
      end
      if (rd_vld_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= '0;
      end
    end else if (rd_vld_q) begin
      acc_q[0] <= acc_q[0] + SUM_W'(rdata[2*CH_W +: CH_W]);
      acc_q[1] <= acc_q[1] + SUM_W'(rdata[CH_W +: CH_W]);
      acc_q[2] <= acc_q[2] + SUM_W'(rdata[0 +: CH_W]);
    end
    if (state_q == ST_MUL) begin
      for (int i = 0; i < 3; i++) begin
        mean_q[i] <= prod[i][RECIP_SH +: CH_W];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_r_q   <= mean_q[0];
      out_g_q   <= mean_q[1];
      out_b_q   <= mean_q[2];
      out_fin_q <= gfin_q;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.red_out   = out_r_q;
  assign res_o.green_out = out_g_q;
  assign res_o.blue_out  = out_b_q;
  assign res_o.frame_end = out_fin_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(w_q) + PW'(1))
    else $error("pending count beyond one row plus one");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= h_q)
    else $error("input row beyond frame height");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (cnt_q != '0))
    else $error("mean with empty neighborhood");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && gfin_q) |-> (in_row_q == '0 && pend_q == '0))
    else $error("frame not restarted after last word");

  a_gather_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LAST) |-> ($past(state_q) == ST_GATHER && $past(last_slot)))
    else $error("neighbor sweep cut short");
`endif

endmodule

/* test/tb_rgb_box_blur_3x3_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_box_blur_3x3_top
// Self-checking bench for the RGB 3x3 box blur. A cycle-free model of the
// filter tracks the line rows, raster positions and frame size, and queues
// the mean due whenever an accepted pixel or drain word yields one. Directed
// tests cover the reset size, one-pixel images, border divisors, ignored
// drains and extra pixels, frame wrap, register restarts, unused register
// indexes and the largest size. Random frames of random shape follow. Both
// handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_box_blur_3x3_top;
  import rbb_pkg::*;

  localparam int unsigned MAX_W          = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H          = MAX_HEIGHT_DEF;
  localparam int unsigned COL_W          = $clog2(MAX_W);
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_WORDS   = 500;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 4'd15;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } mean_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rbb_cfg_if cfg_bus ();
  rbb_pix_if pix_bus ();
  rbb_res_if res_bus ();

  rgb_box_blur_3x3_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .pix_i  (pix_bus),
    .res_o  (res_bus)
  );

  always #1 clk_i = ~clk_i;

  // filter model state
  logic [PIX_W-1:0]      src_rows [4][MAX_W];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  int unsigned           in_col;
  int unsigned           in_row;
  int unsigned           out_pos;
  mean_t                 expected_means [$];

  int unsigned fail_count;
  int unsigned n_pix;
  int unsigned n_drain;
  int unsigned n_ignored;
  int unsigned n_cfg;
  int unsigned n_means;
  int unsigned n_frames;
  int unsigned idle_cycles;
  int unsigned rx_hold;
  bit          tx_steady;
  bit          rx_steady;

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_w();
    return clamp_dim(width_reg, MAX_W);
  endfunction

  function automatic int unsigned frame_h();
    return clamp_dim(height_reg, MAX_H);
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_pos = 0;
  endfunction

  function automatic mean_t next_mean(int unsigned w, int unsigned h);
    mean_t            m;
    int unsigned      row, col, sr, sg, sb, cnt;
    int               r, c;
    logic [PIX_W-1:0] p;
    row = out_pos / w;
    col = out_pos % w;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = int'(row) + dr;
        c = int'(col) + dc;
        if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
          p   = src_rows[2'(r)][COL_W'(c)];
          sr += 32'(p[2*CH_W +: CH_W]);
          sg += 32'(p[CH_W +: CH_W]);
          sb += 32'(p[0 +: CH_W]);
          cnt++;
        end
      end
    end
    m.red   = CH_W'(sr / cnt);
    m.green = CH_W'(sg / cnt);
    m.blue  = CH_W'(sb / cnt);
    if (out_pos + 1 == w * h) begin
      m.frame_end = 1'b1;
      restart_frame();
    end else begin
      m.frame_end = 1'b0;
      out_pos++;
    end
    return m;
  endfunction

  // 1 when the word belongs to the frame, 0 when the block drops it
  function automatic bit blur_predict_word(logic cmd, logic [CH_W-1:0] r,
                                           logic [CH_W-1:0] g, logic [CH_W-1:0] b);
    int unsigned w, h;
    w = frame_w();
    h = frame_h();
    if (cmd == CMD_DRAIN) begin
      if (in_row < h) return 0;
      expected_means.insert(expected_means.size(), next_mean(w, h));
      return 1;
    end
    if (in_row >= h) return 0;
    src_rows[2'(in_row)][COL_W'(in_col)] = {r, g, b};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (out_pos + w + 2 <= in_row * w + in_col) begin
      expected_means.insert(expected_means.size(), next_mean(w, h));
    end
    return 1;
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.cmd      <= cmd;
    pix_bus.red_in   <= r;
    pix_bus.green_in <= g;
    pix_bus.blue_in  <= b;
    do @(posedge clk_i); while (!pix_bus.ready);
    if (!blur_predict_word(cmd, r, g, b)) n_ignored++;
    else if (cmd == CMD_DRAIN) n_drain++;
    else n_pix++;
  endtask

  task automatic send_pixel();
    send_word(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic finish_frame();
    while (in_row >= frame_h()) send_word(CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
  endtask

  // hold the pixel channel until every queued mean is back
  task automatic wait_means(bit settle);
    pix_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_means.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    repeat (1 + pick_gap(tx_steady)) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = data;
      restart_frame();
    end else if (idx == CFG_FRAME_HEIGHT) begin
      height_reg = data;
      restart_frame();
    end
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_means(1'b1);
    cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic test_reset_size();
    repeat (FRAME_WIDTH_RST + 10) send_pixel();
  endtask

  task automatic test_small_frames();
    set_frame(0, 0);
    send_word(CMD_DRAIN, '1, '1, '1);
    send_word(CMD_PIXEL, '1, '0, '1);
    send_word(CMD_PIXEL, 8'd1, 8'd2, 8'd3);
    finish_frame();
    send_word(CMD_PIXEL, '0, '1, '0);
    finish_frame();
    set_frame(1, 4);
    repeat (4) send_pixel();
    finish_frame();
    set_frame(6, 1);
    repeat (6) send_pixel();
    finish_frame();
    set_frame(2, 2);
    repeat (4) send_pixel();
    finish_frame();
  endtask

  task automatic test_border_means();
    set_frame(3, 3);
    for (int k = 0; k < 9; k++) begin
      if (k % 2 == 1) send_word(CMD_PIXEL, '1, '1, '1);
      else send_word(CMD_PIXEL, '0, '0, '0);
    end
    finish_frame();
    set_frame(4, 3);
    repeat (12) send_word(CMD_PIXEL, '1, '1, '1);
    finish_frame();
    set_frame(5, 4);
    repeat (20) send_pixel();
    finish_frame();
  endtask

  task automatic test_unused_index();
    set_frame(4, 3);
    repeat (5) send_pixel();
    wait_means(1'b1);
    cfg_write(CFG_UNUSED_LOW, '1);
    cfg_write(CFG_UNUSED_TOP, '0);
    repeat (7) send_pixel();
    finish_frame();
  endtask

  task automatic test_restart();
    set_frame(4, 3);
    repeat (9) send_pixel();
    set_frame(4, 3);
    repeat (12) send_pixel();
    finish_frame();
  endtask

  task automatic test_max_size();
    set_frame(4095, MAX_H + 1);
    repeat (MAX_W / 64) send_pixel();
    set_frame(3, MAX_H + 1);
    repeat (MAX_W / 64) send_pixel();
  endtask

  task automatic test_random_frames();
    int unsigned base, w, h, n_px, r;
    bit          first, need_cfg, cut;
    base     = n_pix + n_drain;
    first    = 1'b1;
    need_cfg = 1'b1;
    while (n_pix + n_drain - base < RANDOM_WORDS) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if (need_cfg || $urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 75) w = $urandom_range(1, 10);
        else if (r < 95) w = $urandom_range(11, 40);
        else w = $urandom_range(41, 160);
        if (w > 40) h = $urandom_range(1, 4);
        else if ($urandom_range(0, 4) == 0) h = $urandom_range(7, 24);
        else h = $urandom_range(1, 6);
        set_frame(w, h);
        need_cfg = 1'b0;
      end
      n_px = frame_w() * frame_h();
      cut  = ($urandom_range(0, 19) == 0);
      if (cut) n_px = $urandom_range(1, n_px);
      for (int unsigned k = 0; k < n_px; k++) begin
        if ($urandom_range(0, 32) == 0) send_word(CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
        if (k == n_px / 2 && (first || $urandom_range(0, 7) == 0)) wait_means(1'b0);
        send_pixel();
      end
      first = 1'b0;
      if (cut) begin
        need_cfg = 1'b1;
      end else begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_pixel();
        finish_frame();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      rx_hold       <= 0;
    end else if (rx_hold != 0) begin
      res_bus.ready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      res_bus.ready <= 1'b1;
      rx_hold       <= pick_gap(rx_steady);
    end
  end

  always @(posedge clk_i) begin
    mean_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_means.size() == 0) begin
        $error("unexpected mean word: red %0d green %0d blue %0d frame_end %0b",
               res_bus.red_out, res_bus.green_out, res_bus.blue_out, res_bus.frame_end);
        fail_count++;
      end else begin
        want = expected_means.pop_front();
        n_means++;
        if (want.frame_end) n_frames++;
        if (res_bus.red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, res_bus.red_out);
          fail_count++;
        end
        if (res_bus.green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, res_bus.green_out);
          fail_count++;
        end
        if (res_bus.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, res_bus.blue_out);
          fail_count++;
        end
        if (res_bus.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, res_bus.frame_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d means outstanding",
               idle_cycles, expected_means.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    pix_bus.valid    = 1'b0;
    pix_bus.cmd      = CMD_PIXEL;
    pix_bus.red_in   = '0;
    pix_bus.green_in = '0;
    pix_bus.blue_in  = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_FRAME_WIDTH;
    cfg_bus.data     = '0;
    res_bus.ready    = 1'b0;
    width_reg        = CFG_DATA_W'(FRAME_WIDTH_RST);
    height_reg       = CFG_DATA_W'(FRAME_HEIGHT_RST);
    restart_frame();
    fail_count = 0;
    n_pix      = 0;
    n_drain    = 0;
    n_ignored  = 0;
    n_cfg      = 0;
    n_means    = 0;
    n_frames   = 0;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_small_frames();
    test_border_means();
    test_unused_index();
    test_restart();
    test_max_size();
    test_random_frames();
    wait_means(1'b1);
    $display("Covered %0d pixel words, %0d drain words, %0d dropped words, %0d register writes",
             n_pix, n_drain, n_ignored, n_cfg);
    $display("Checked %0d means over %0d whole frames, %0d mismatches",
             n_means, n_frames, fail_count);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/rbb_pkg.sv
src/rbb_if.sv
src/rbb_line_mem.sv
src/rgb_box_blur_3x3_top.sv
test/tb_rgb_box_blur_3x3_top.sv
